@@ sv/sbs_pkg.sv @@
// Shared types and constants for the spectrum band summer.
`default_nettype none

package sbs_pkg;

    // Field widths.
    localparam int BIN_W     = 16;
    localparam int SUM_W     = 23;
    localparam int BAND_W    = 3;
    localparam int EDGE_W    = 8;
    localparam int CNT_W     = 8;
    localparam int NUM_EDGES = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_0     = 3'd1;

    // Reset values of the configuration registers.
    localparam logic [BAND_W-1:0] BAND_COUNT_RST = 3'd1;
    localparam logic [EDGE_W-1:0] EDGE_0_RST     = 8'd0;
    localparam logic [EDGE_W-1:0] EDGE_N_RST     = 8'd128;

    // Largest value a band sum can hold.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [BAND_W-1:0]                  band_count;
        logic [NUM_EDGES-1:0][EDGE_W-1:0]   edges;
    } t_cfg;

    // One finished band.
    typedef struct packed {
        logic [SUM_W-1:0]  band_sum;
        logic [BAND_W-1:0] band_number;
        logic              last_band;
    } t_result;

endpackage

`default_nettype wire

@@ sv/sbs_cfg.sv @@
// Configuration register file: band count and band edges.
`default_nettype none

module sbs_cfg
    import sbs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [BAND_W-1:0]                r_band_count;
    logic [NUM_EDGES-1:0][EDGE_W-1:0] r_edges;
    logic [CFG_IDX_W-1:0]             s_edge_idx;

    // Edge registers start at index CFG_EDGE_0 and follow in edge order.
    assign s_edge_idx = i_cfg_index - CFG_EDGE_0;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_count <= BAND_COUNT_RST;
            for (int k = 0; k < NUM_EDGES; k++) begin
                r_edges[k] <= (k == 0) ? EDGE_0_RST : EDGE_N_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BAND_COUNT: r_band_count <= i_cfg_data[BAND_W-1:0];
                default:        r_edges[s_edge_idx] <= i_cfg_data[EDGE_W-1:0];
            endcase
        end
    end

    assign o_cfg.band_count = r_band_count;
    assign o_cfg.edges      = r_edges;

endmodule

`default_nettype wire

@@ sv/sbs_accum.sv @@
// Band accumulator: bin counter, band pointer and running sum for one frame.
`default_nettype none

module sbs_accum
    import sbs_pkg::*;
#(
    parameter int WINDOW_SIZE = 256,
    parameter int MAX_BANDS   = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_go,
    input  wire logic [BIN_W-1:0] i_bin_value,
    input  wire logic             i_last_bin,
    output logic                  o_emit,
    output t_result               o_result
);

    // Counter stops at the last index of the window, never above 255.
    localparam int CNT_LIMIT_I = (WINDOW_SIZE - 1 > 255) ? 255 : WINDOW_SIZE - 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_LIMIT_I[CNT_W-1:0];
    // Band count is capped at the number of bands built in.
    localparam int CAP_I = (MAX_BANDS < 1) ? 1 : ((MAX_BANDS > 6) ? 6 : MAX_BANDS);
    localparam logic [BAND_W-1:0] BAND_CAP = CAP_I[BAND_W-1:0];

    logic [CNT_W-1:0]  r_bin_cnt;
    logic [BAND_W-1:0] r_band_ptr;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  n_bin_cnt;
    logic [BAND_W-1:0] n_band_ptr;
    logic [SUM_W-1:0]  n_sum;

    logic [BAND_W-1:0] s_used;
    logic [EDGE_W-1:0] s_end_edge;
    logic              s_active;
    logic [SUM_W:0]    s_add;
    logic [SUM_W-1:0]  s_sat;
    logic [BAND_W-1:0] s_ptr_inc;

    // Effective band count: zero acts as one, large values hit the cap.
    always_comb begin
        if (i_cfg.band_count == '0) begin
            s_used = BAND_W'(1);
        end else if (i_cfg.band_count > BAND_CAP) begin
            s_used = BAND_CAP;
        end else begin
            s_used = i_cfg.band_count;
        end
    end

    // End edge of the current band; pointer seven lies beyond the edge array and reads as zero.
    assign s_end_edge = (r_band_ptr < BAND_W'(NUM_EDGES)) ?
                        i_cfg.edges[r_band_ptr] : '0;

    assign s_active = (r_bin_cnt >= i_cfg.edges[0]) && (r_band_ptr != '0) &&
                      (r_band_ptr <= s_used);

    // Saturating add of the bin into the running sum.
    assign s_add = {1'b0, r_sum} + {{(SUM_W + 1 - BIN_W){1'b0}}, i_bin_value};
    assign s_sat = s_add[SUM_W] ? SUM_MAX : s_add[SUM_W-1:0];

    assign s_ptr_inc = r_band_ptr + BAND_W'(1);

    // The band closes at the first bin at or beyond its end edge.
    assign o_emit                = s_active && (r_bin_cnt >= s_end_edge);
    assign o_result.band_sum     = r_sum;
    assign o_result.band_number  = r_band_ptr - BAND_W'(1);
    assign o_result.last_band    = (r_band_ptr == s_used);

    // Next frame state.
    always_comb begin
        n_band_ptr = r_band_ptr;
        n_sum      = r_sum;
        n_bin_cnt  = r_bin_cnt;
        if (s_active) begin
            if (o_emit) begin
                n_band_ptr = s_ptr_inc;
                n_sum      = (s_ptr_inc <= s_used) ?
                             {{(SUM_W - BIN_W){1'b0}}, i_bin_value} : '0;
            end else begin
                n_sum = s_sat;
            end
        end
        if (i_last_bin) begin
            n_bin_cnt  = '0;
            n_band_ptr = BAND_W'(1);
            n_sum      = '0;
        end else if (r_bin_cnt < CNT_LIMIT) begin
            n_bin_cnt = r_bin_cnt + CNT_W'(1);
        end
    end

    // State registers advance once per processed bin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt  <= '0;
            r_band_ptr <= BAND_W'(1);
            r_sum      <= '0;
        end else if (i_go) begin
            r_bin_cnt  <= n_bin_cnt;
            r_band_ptr <= n_band_ptr;
            r_sum      <= n_sum;
        end
    end

endmodule

`default_nettype wire

@@ sv/spectrum_band_summer.sv @@
// Top level of the spectrum band summer: input register, accumulator, result register.
`default_nettype none

// Sums spectrum bins of one frame into up to six bands set by the edge
// registers and emits one result per finished band. A bin is taken into an
// input register, processed there against the frame state, and a finished
// band is placed in an output register. Throughput is one bin per clock
// cycle unless a closing bin waits on a full output register.
// A bin whose band result cannot be stored while the output register still
// holds an unaccepted band waits in the input register until the output side
// takes that band. The user must write the configuration through the plain
// write port only while the block is idle; the block does not enforce it.
module spectrum_band_summer
    import sbs_pkg::*;
#(
    parameter int WINDOW_SIZE = 256,
    parameter int MAX_BANDS   = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // Bin input channel.
    input  wire logic                 i_bin_valid,
    output logic                      o_bin_ready,
    input  wire logic [BIN_W-1:0]     i_bin_value,
    input  wire logic                 i_last_bin,
    // Band output channel.
    output logic                      o_band_valid,
    input  wire logic                 i_band_ready,
    output logic [SUM_W-1:0]          o_band_sum,
    output logic [BAND_W-1:0]         o_band_number,
    output logic                      o_last_band
);

    t_cfg             s_cfg;
    logic             r_in_valid;
    logic [BIN_W-1:0] r_in_bin;
    logic             r_in_last;
    logic             s_emit;
    t_result          s_result;
    logic             s_out_free;
    logic             s_go;
    logic             r_out_valid;
    t_result          r_out;

    sbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (s_cfg)
    );

    sbs_accum #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_BANDS   (MAX_BANDS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (s_cfg),
        .i_go        (s_go),
        .i_bin_value (r_in_bin),
        .i_last_bin  (r_in_last),
        .o_emit      (s_emit),
        .o_result    (s_result)
    );

    // A bin proceeds unless it closes a band and the output register is full and not read.
    assign s_out_free  = !r_out_valid || i_band_ready;
    assign s_go        = r_in_valid && (!s_emit || s_out_free);
    assign o_bin_ready = !r_in_valid || s_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_bin_ready) begin
            r_in_valid <= i_bin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_bin_ready && i_bin_valid) begin
            r_in_bin  <= i_bin_value;
            r_in_last <= i_last_bin;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go && s_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_band_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && s_emit) begin
            r_out <= s_result;
        end
    end

    assign o_band_valid  = r_out_valid;
    assign o_band_sum    = r_out.band_sum;
    assign o_band_number = r_out.band_number;
    assign o_last_band   = r_out.last_band;

    // A band number never reaches the number of bands built in.
    a_band_number_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_band_valid |-> (int'(o_band_number) < MAX_BANDS))
        else $error("band number out of range");

    // An empty input register always takes the next transfer.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_bin_ready)
        else $error("input stalled while empty");

    // A closed band shows up on the output in the next cycle.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && s_emit) |=> o_band_valid)
        else $error("finished band not presented");

endmodule

`default_nettype wire

@@ sim/spectrum_band_summer_tb.sv @@
// Self-checking testbench for the spectrum band summer: directed and random frames.
`default_nettype none

module spectrum_band_summer_tb;
    import sbs_pkg::*;

    localparam int WINDOW_SIZE   = 256;
    localparam int MAX_BANDS     = 6;
    localparam int COUNT_LIMIT   = (WINDOW_SIZE - 1 > 255) ? 255 : WINDOW_SIZE - 1;
    localparam int RANDOM_BINS   = 250;
    localparam int LONG_STALL    = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    // One bin as offered on the input channel.
    typedef struct packed {
        logic [BIN_W-1:0] value;
        logic             last;
    } t_bin_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 i_bin_valid = 1'b0;
    logic                 o_bin_ready;
    logic [BIN_W-1:0]     i_bin_value = '0;
    logic                 i_last_bin  = 1'b0;
    logic                 o_band_valid;
    logic                 i_band_ready = 1'b0;
    logic [SUM_W-1:0]     o_band_sum;
    logic [BAND_W-1:0]    o_band_number;
    logic                 o_last_band;

    // Shadow of the configuration registers and of the frame state.
    logic [BAND_W-1:0] cfg_band_count;
    logic [EDGE_W-1:0] cfg_edges [NUM_EDGES];
    logic [CNT_W-1:0]  frame_bin_idx;
    logic [BAND_W-1:0] band_ptr;
    logic [SUM_W-1:0]  band_acc;

    t_bin_item pending_bins [$];
    t_result   band_expect [$];
    t_bin_item next_bin;
    t_result   got_band;
    t_result   want_band;

    int unsigned bins_queued     = 0;
    int unsigned bins_accepted   = 0;
    int unsigned random_bins     = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    // Sender and receiver idling controls, set per phase.
    int unsigned send_gap_max   = 0;
    int unsigned send_burst_max = 0;
    int unsigned gap_left       = 0;
    int unsigned burst_left     = 0;
    int unsigned stall_left     = 0;
    bit          long_stall_req = 1'b0;
    logic [15:0] ready_pattern  = 16'hFFFF;

    spectrum_band_summer #(
        .WINDOW_SIZE(WINDOW_SIZE),
        .MAX_BANDS  (MAX_BANDS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_bin_valid  (i_bin_valid),
        .o_bin_ready  (o_bin_ready),
        .i_bin_value  (i_bin_value),
        .i_last_bin   (i_last_bin),
        .o_band_valid (o_band_valid),
        .i_band_ready (i_band_ready),
        .o_band_sum   (o_band_sum),
        .o_band_number(o_band_number),
        .o_last_band  (o_last_band)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Adds one accepted bin to the current band and predicts a finished band.
    task automatic accumulate_bin(input logic [BIN_W-1:0] bin, input logic last);
        int unsigned    n;
        logic [SUM_W:0] wide;
        t_result        band;
        n = cfg_band_count;
        if (n < 1) n = 1;
        if (n > MAX_BANDS) n = MAX_BANDS;
        if (frame_bin_idx >= cfg_edges[0] && band_ptr >= 1 && band_ptr <= n) begin
            if (frame_bin_idx < cfg_edges[band_ptr]) begin
                wide = band_acc + bin;
                band_acc = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
            end else begin
                band.band_sum    = band_acc;
                band.band_number = band_ptr - 1'b1;
                band.last_band   = (band_ptr == n);
                band_expect.push_back(band);
                band_ptr = band_ptr + 1'b1;
                band_acc = (band_ptr <= n) ? SUM_W'(bin) : '0;
            end
        end
        if (last) begin
            frame_bin_idx = '0;
            band_ptr      = 3'd1;
            band_acc      = '0;
        end else if (frame_bin_idx < COUNT_LIMIT) begin
            frame_bin_idx = frame_bin_idx + 1'b1;
        end
    endtask

    task automatic push_bin(input logic [BIN_W-1:0] value, input logic last);
        t_bin_item item;
        item.value = value;
        item.last  = last;
        pending_bins.push_back(item);
        bins_queued++;
    endtask

    // Writes every register from the shadow copy; the block is idle here.
    task automatic load_config();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BAND_COUNT;
        i_cfg_data  <= CFG_DAT_W'(cfg_band_count);
        @(posedge i_clk);
        for (int k = 0; k < NUM_EDGES; k++) begin
            i_cfg_index <= CFG_IDX_W'(CFG_EDGE_0 + k);
            i_cfg_data  <= cfg_edges[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_edges(input int e0, input int e1, input int e2, input int e3,
                             input int e4, input int e5, input int e6);
        cfg_edges[0] = EDGE_W'(e0);
        cfg_edges[1] = EDGE_W'(e1);
        cfg_edges[2] = EDGE_W'(e2);
        cfg_edges[3] = EDGE_W'(e3);
        cfg_edges[4] = EDGE_W'(e4);
        cfg_edges[5] = EDGE_W'(e5);
        cfg_edges[6] = EDGE_W'(e6);
    endtask

    // Picks band count and edges: mostly increasing, sometimes arbitrary.
    task automatic randomize_config();
        int unsigned shape;
        int unsigned e;
        cfg_band_count = BAND_W'($urandom_range(0, 7));
        shape = $urandom_range(0, 9);
        e = (shape == 7) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        for (int k = 0; k < NUM_EDGES; k++) begin
            if (shape == 8) begin
                e = $urandom_range(0, 255);
            end else if (k > 0) begin
                if (shape == 9) e = e + $urandom_range(0, 3) - $urandom_range(0, 2);
                else if (shape == 7) e = e + $urandom_range(1, 15);
                else e = e + $urandom_range(1, 12);
            end
            cfg_edges[k] = EDGE_W'(e > 255 ? 255 : e);
        end
    endtask

    // Queues one frame sized from the used edges; some frames end early or run long.
    task automatic queue_random_frame();
        int unsigned n;
        int unsigned top_edge;
        int unsigned len;
        int unsigned shape;
        int unsigned value_kind;
        logic [BIN_W-1:0] value;
        n = cfg_band_count;
        if (n < 1) n = 1;
        if (n > MAX_BANDS) n = MAX_BANDS;
        top_edge = 0;
        for (int k = 0; k <= n; k++) begin
            if (cfg_edges[k] > top_edge) top_edge = cfg_edges[k];
        end
        shape = $urandom_range(0, 39);
        if (shape < 30) len = top_edge + 1 + $urandom_range(0, 3);
        else if (shape < 39) len = $urandom_range(1, top_edge + 2);
        else len = $urandom_range(250, 300);
        value_kind = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            case (value_kind)
                0: value = BIN_W'($urandom_range(0, 255));
                1: value = BIN_W'(16'hFFFF - $urandom_range(0, 15));
                default: begin
                    case ($urandom_range(0, 7))
                        0: value = '0;
                        1: value = '1;
                        default: value = BIN_W'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            push_bin(value, i == len - 1);
        end
        random_bins += len;
    endtask

    // Waits until all queued bins are taken and all bands have arrived.
    task automatic finish_phase();
        while (bins_accepted != bins_queued) @(posedge i_clk);
        while (band_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Bin driver: bursts with random gaps, payload held until the transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_bin_valid <= 1'b0;
        end else begin
            if (i_bin_valid && o_bin_ready) begin
                accumulate_bin(i_bin_value, i_last_bin);
                bins_accepted++;
            end
            if (!i_bin_valid || o_bin_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_bin_valid <= 1'b0;
                end else if (pending_bins.size() > 0) begin
                    next_bin = pending_bins.pop_front();
                    i_bin_value <= next_bin.value;
                    i_last_bin  <= next_bin.last;
                    i_bin_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, send_burst_max);
                        gap_left   = $urandom_range(0, send_gap_max);
                    end
                end else begin
                    i_bin_valid <= 1'b0;
                end
            end
        end
    end

    // Band receiver: rotating ready pattern, with an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_band_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_band_ready <= 1'b0;
        end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left     = LONG_STALL;
            i_band_ready <= 1'b0;
        end else begin
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            i_band_ready <= ready_pattern[0];
        end
    end

    // Band monitor: each transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_band_valid && i_band_ready) begin
            got_band.band_sum    = o_band_sum;
            got_band.band_number = o_band_number;
            got_band.last_band   = o_last_band;
            if (band_expect.size() == 0) begin
                $error("unexpected band transfer: band_sum %0d band_number %0d last_band %0d",
                       got_band.band_sum, got_band.band_number, got_band.last_band);
                error_count++;
            end else begin
                want_band = band_expect.pop_front();
                if (got_band.band_sum !== want_band.band_sum) begin
                    $error("band_sum mismatch: expected %0d, actual %0d",
                           want_band.band_sum, got_band.band_sum);
                    error_count++;
                end
                if (got_band.band_number !== want_band.band_number) begin
                    $error("band_number mismatch: expected %0d, actual %0d",
                           want_band.band_number, got_band.band_number);
                    error_count++;
                end
                if (got_band.last_band !== want_band.last_band) begin
                    $error("last_band mismatch: expected %0d, actual %0d",
                           want_band.last_band, got_band.last_band);
                    error_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned phase_idx;
        cfg_band_count = BAND_COUNT_RST;
        cfg_edges[0]   = EDGE_0_RST;
        for (int k = 1; k < NUM_EDGES; k++) cfg_edges[k] = EDGE_N_RST;
        frame_bin_idx = '0;
        band_ptr      = 3'd1;
        band_acc      = '0;
        phase_idx     = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a short frame that never reaches the first end edge.
        push_bin(16'hFFFF, 1'b0);
        push_bin(16'h0000, 1'b0);
        push_bin(16'h8000, 1'b1);
        finish_phase();

        // Band count zero acts as one; the frame ends on the closing bin,
        // then a frame is cut short inside the band.
        cfg_band_count = 3'd0;
        set_edges(2, 5, 128, 128, 128, 128, 128);
        load_config();
        push_bin(16'd7, 1'b0);
        push_bin(16'hFFFF, 1'b0);
        push_bin(16'd1, 1'b0);
        push_bin(16'd2, 1'b0);
        push_bin(16'd3, 1'b0);
        push_bin(16'd4, 1'b1);
        push_bin(16'd9, 1'b0);
        push_bin(16'd9, 1'b0);
        push_bin(16'd9, 1'b1);
        finish_phase();

        // Band count above the maximum acts as six; one band closes per bin,
        // and bins after the last band are ignored.
        cfg_band_count = 3'd7;
        set_edges(0, 1, 2, 3, 4, 5, 6);
        load_config();
        for (int i = 0; i < 9; i++) push_bin(BIN_W'(16'h1111 * (i + 1)), i == 8);
        finish_phase();

        // Edges that repeat or go backwards. Bands close on consecutive bins
        // while the receiver is held off, so the block fills and stalls.
        cfg_band_count = 3'd6;
        set_edges(1, 4, 4, 2, 7, 7, 9);
        load_config();
        long_stall_req = 1'b1;
        for (int i = 0; i < 10; i++) push_bin(BIN_W'(100 + i), i == 9);
        finish_phase();

        // A long frame of full-scale bins: the sum saturates and the
        // bin counter stops at its limit.
        cfg_band_count = 3'd1;
        set_edges(0, 255, 255, 255, 255, 255, 255);
        load_config();
        for (int i = 0; i < 270; i++) push_bin(16'hFFFF, i == 269);
        finish_phase();

        // Random phases with varied idling on both sides.
        while (random_bins < RANDOM_BINS) begin
            randomize_config();
            load_config();
            case ($urandom_range(0, 3))
                0: begin
                    send_gap_max   = 0;
                    send_burst_max = 0;
                end
                1: begin
                    send_gap_max   = 3;
                    send_burst_max = 8;
                end
                default: begin
                    send_gap_max   = 10;
                    send_burst_max = 4;
                end
            endcase
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : 16'($urandom_range(1, 65535));
            // The first random phase starts with the receiver held off.
            if (phase_idx == 0) begin
                send_gap_max   = 0;
                long_stall_req = 1'b1;
            end
            for (int f = $urandom_range(2, 6); f > 0 && random_bins < RANDOM_BINS; f--) begin
                queue_random_frame();
            end
            finish_phase();
            phase_idx++;
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ spectrum_band_summer.f @@
sv/sbs_pkg.sv
sv/sbs_cfg.sv
sv/sbs_accum.sv
sv/spectrum_band_summer.sv
sim/spectrum_band_summer_tb.sv
